// ===== sv/mvc_pkg.sv =====
// Shared constants, types and helper functions for the multi-voice chorus.
package mvc_pkg;

    localparam int DELAY_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FRAC_W      = 8;
    localparam int POS_W       = ADDR_W + FRAC_W;
    localparam int SAMPLE_W    = 16;
    localparam int PHASE_W     = 24;
    localparam int SINE_SIZE   = 256;
    localparam int SINE_BITS   = $clog2(SINE_SIZE);
    localparam int LFO_W       = 17;
    localparam int WEIGHT_W    = 17;

    localparam int BASE_W      = 21;
    localparam int MIX_W       = 16;
    localparam int SHAPE_W     = 2;
    localparam int MODE_W      = 2;
    localparam int VC_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // shared multiplier and datapath widths
    localparam int MUL_A_W     = 38;
    localparam int MUL_B_W     = 18;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int H_W         = 47;
    localparam int VAL_W       = 30;
    localparam int ACC_W       = 50;
    localparam int FIN_W       = 67;
    localparam int WET_LO_W    = 25;

    localparam logic [POS_W-1:0] DELAY_LIMIT = POS_W'((DELAY_DEPTH - 3) << FRAC_W);
    localparam logic [LFO_W-1:0] LFO_ONE     = LFO_W'(65536);
    localparam logic [LFO_W-1:0] LFO_HALF    = LFO_W'(32768);
    localparam logic [WEIGHT_W-1:0] W_ONE        = WEIGHT_W'(65536);
    localparam logic [WEIGHT_W-1:0] W_THIRD      = WEIGHT_W'(65536 / 3);
    localparam logic [WEIGHT_W-1:0] W_TWO_THIRDS = WEIGHT_W'(131072 / 3);

    localparam logic [PHASE_W-1:0] OFF_HALF       = PHASE_W'(64'd1 << (PHASE_W - 1));
    localparam logic [PHASE_W-1:0] OFF_QUARTER    = PHASE_W'(64'd1 << (PHASE_W - 2));
    localparam logic [PHASE_W-1:0] OFF_THIRD      = PHASE_W'((64'd1 << PHASE_W) / 3);
    localparam logic [PHASE_W-1:0] OFF_TWO_THIRDS = PHASE_W'((64'd2 << PHASE_W) / 3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DELAY    = 3'd0,
        CFG_SWEEP_WIDTH   = 3'd1,
        CFG_MIX_DEPTH     = 3'd2,
        CFG_PHASE_STEP    = 3'd3,
        CFG_LFO_SHAPE     = 3'd4,
        CFG_INTERP_MODE   = 3'd5,
        CFG_VOICE_COUNT   = 3'd6,
        CFG_STEREO_SPREAD = 3'd7
    } t_cfg_reg;

    typedef enum logic [SHAPE_W-1:0] {
        LFO_SINE     = 2'd0,
        LFO_TRIANGLE = 2'd1,
        LFO_SQUARE   = 2'd2,
        LFO_SAW      = 2'd3
    } t_lfo_shape;

    localparam logic [MODE_W-1:0] INTERP_NEAREST = 2'd0;
    localparam logic [MODE_W-1:0] INTERP_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] INTERP_CUBIC   = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LFO, ST_DMUL, ST_DEL, ST_POS, ST_RD, ST_RDW,
        ST_IPREP, ST_IMUL, ST_IDONE, ST_WMUL, ST_FLO, ST_FHI, ST_FSAT,
        ST_WRITE, ST_OUT
    } t_state;

    typedef logic [LFO_W-1:0] t_sine_tab [SINE_SIZE];

    // Sine entries from a Q30 Taylor series, evaluated at elaboration.
    function automatic t_sine_tab sine_build();
        t_sine_tab   tab;
        logic [63:0] p, quad, r, x, x2, t, s, v;
        for (int k = 0; k < SINE_SIZE; k++) begin
            p    = 64'(k) << (32 - SINE_BITS);
            quad = (p >> 30) & 64'd3;
            r    = p & ((64'd1 << 30) - 64'd1);
            if (quad[0]) begin
                r = (64'd1 << 30) - r;
            end
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
            t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            if (s > (64'd1 << 30)) begin
                s = 64'd1 << 30;
            end
            v = (quad < 64'd2) ? (64'd1 << 30) + s : (64'd1 << 30) - s;
            tab[k] = LFO_W'((v + (64'd1 << 14)) >> 15);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = sine_build();

    // Phase offset of voice j among vc-1 delayed voices.
    function automatic logic [PHASE_W-1:0] voice_offset(input logic [VC_W-1:0] vc,
                                                        input logic [1:0] j);
        logic [PHASE_W-1:0] off;
        off = '0;
        unique case (vc)
            3'd3: off = j[0] ? OFF_HALF : '0;
            3'd4: off = (j == 2'd1) ? OFF_THIRD : ((j == 2'd2) ? OFF_TWO_THIRDS : '0);
            3'd5: off = PHASE_W'(j) * OFF_QUARTER;
            default: off = '0;
        endcase
        return off;
    endfunction

    // Left pan weight of voice j when spreading, Q16.
    function automatic logic [WEIGHT_W-1:0] pan_weight(input logic [VC_W-1:0] vc,
                                                       input logic [1:0] j);
        logic [WEIGHT_W-1:0] w;
        w = W_ONE;
        unique case (vc)
            3'd3: w = j[0] ? W_ONE : '0;
            3'd4: w = WEIGHT_W'(j) << 15;
            3'd5: begin
                unique case (j)
                    2'd0: w = '0;
                    2'd1: w = W_THIRD;
                    2'd2: w = W_TWO_THIRDS;
                    default: w = W_ONE;
                endcase
            end
            default: w = W_ONE;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/multi_voice_chorus.sv =====
// Top level of the stereo multi-voice chorus with shared LFO and delay lines.
//
// One stereo word in gives one stereo word out. After reset the block sweeps
// both 8192-entry delay lines to zero, one entry per cycle, and takes no
// input word until that pass ends; configuration writes are taken at any
// time. Each input word is then worked by a sequencer around one shared
// 38x18 signed multiplier: per delayed voice LFO, delay multiply, delay and
// position steps, a read and a read-wait step per delay-line tap (1, 2 or 4
// taps for nearest, linear or cubic), and per channel a prepare step, 0, 1
// or 3 interpolation multiplies, a done step and a weight multiply; then per
// channel a low and a high mix multiply and a saturation step, a write and
// an output step. The input side is ready only while the sequencer is idle;
// a finished word waits in the output register while the next one is worked.
module multi_voice_chorus
    import mvc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [15:0] left_in, [31:16] right_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration registers
    logic [BASE_W-1:0]  r_base_delay;
    logic [BASE_W-1:0]  r_sweep_width;
    logic [MIX_W-1:0]   r_mix_depth;
    logic [PHASE_W-1:0] r_phase_step;
    logic [SHAPE_W-1:0] r_lfo_shape;
    logic [MODE_W-1:0]  r_interp_mode;
    logic [VC_W-1:0]    r_voice_count;
    logic               r_stereo_spread;

    // frame state
    logic [ADDR_W-1:0]  r_wi;
    logic [PHASE_W-1:0] r_phase;
    logic [ADDR_W-1:0]  r_clr;

    // per-word working registers
    logic signed [SAMPLE_W-1:0] r_dl, r_dr;
    logic [VC_W-1:0]            r_vc;
    logic [VC_W-1:0]            r_j;
    logic                       r_ch;
    logic [1:0]                 r_tap;
    logic [1:0]                 r_step;
    logic [LFO_W-1:0]           r_lfo;
    logic [WEIGHT_W-1:0]        r_wl, r_wr;
    logic [POS_W-1:0]           r_pos;
    logic signed [H_W-1:0]      r_h;
    logic signed [VAL_W-1:0]    r_val;
    logic signed [ACC_W-1:0]    r_acc_l, r_acc_r;
    logic signed [FIN_W-1:0]    r_fin;
    logic signed [SAMPLE_W-1:0] r_yl;
    logic signed [SAMPLE_W-1:0] r_yr;
    logic signed [SAMPLE_W-1:0] r_xl [4];
    logic signed [SAMPLE_W-1:0] r_xr [4];

    logic                       r_out_valid;
    logic [31:0]                r_out_data;

    // RAM ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata_l, ram_wdata_r;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata_l, ram_rdata_r;

    // shared multiplier
    logic signed [MUL_A_W-1:0] m_a;
    logic signed [MUL_B_W-1:0] m_b;
    logic signed [MUL_P_W-1:0] m_p;

    logic                       in_accept;
    logic                       out_load;
    logic [1:0]                 tap_last;
    logic                       is_cubic, is_linear;
    logic [ADDR_W-1:0]          idx;
    logic [FRAC_W-1:0]          frac;
    logic signed [SAMPLE_W-1:0] x0, x1, x2, x3;
    logic signed [19:0]         a0, a1, a2;
    logic signed [H_W-1:0]      addend;
    logic                       imul_last;
    logic                       spread;
    logic [WEIGHT_W-1:0]        w_left;
    logic [PHASE_W-1:0]         lfo_p;
    logic [LFO_W-1:0]           lfo_val;
    logic [22:0]                dly;
    logic signed [ACC_W-1:0]    wet;
    logic signed [FIN_W-1:0]    rnd;
    logic signed [VAL_W-1:0]    y;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [H_W-1:0]      cubic_round;
    logic [VC_W-1:0]            vc_in;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    // interpolation mode decode; unused code three reads as nearest
    assign is_cubic  = (r_interp_mode == INTERP_CUBIC);
    assign is_linear = (r_interp_mode == INTERP_LINEAR);
    assign tap_last  = is_cubic ? 2'd3 : (is_linear ? 2'd1 : 2'd0);
    assign idx       = r_pos[POS_W-1:FRAC_W];
    assign frac      = r_pos[FRAC_W-1:0];

    always_comb begin
        if (is_cubic) begin
            ram_raddr = idx + ADDR_W'(r_tap) - ADDR_W'(1);
        end else if (is_linear) begin
            ram_raddr = idx + ADDR_W'(r_tap);
        end else begin
            // round to nearest; an index of the depth itself wraps to zero
            ram_raddr = idx + ADDR_W'(r_pos[FRAC_W-1]);
        end
    end

    // taps of the channel being interpolated
    assign x0 = r_ch ? r_xr[0] : r_xl[0];
    assign x1 = r_ch ? r_xr[1] : r_xl[1];
    assign x2 = r_ch ? r_xr[2] : r_xl[2];
    assign x3 = r_ch ? r_xr[3] : r_xl[3];

    // Catmull-Rom coefficients
    assign a0 = -20'(x0) + 20'(x1) * 20'sd3 - 20'(x2) * 20'sd3 + 20'(x3);
    assign a1 = 20'(x0) * 20'sd2 - 20'(x1) * 20'sd5 + 20'(x2) * 20'sd4 - 20'(x3);
    assign a2 = 20'(x2) - 20'(x0);

    // Horner addend for each multiply step
    always_comb begin
        if (is_linear) begin
            addend = H_W'(x0) <<< 8;
        end else begin
            unique case (r_step)
                2'd0:    addend = H_W'(a1) <<< 8;
                2'd1:    addend = H_W'(a2) <<< 16;
                default: addend = H_W'(x1) <<< 25;
            endcase
        end
    end
    assign imul_last   = is_linear ? (r_step == 2'd0) : (r_step == 2'd2);
    assign cubic_round = (r_h + H_W'(65536)) >>> 17;

    // voice weights and LFO phase
    assign spread = r_stereo_spread && (r_vc > 3'd2);
    assign w_left = spread ? pan_weight(r_vc, r_j[1:0]) : W_ONE;
    assign lfo_p  = r_phase + voice_offset(r_vc, r_j[1:0]);

    always_comb begin
        unique case (t_lfo_shape'(r_lfo_shape))
            LFO_TRIANGLE: begin
                if (lfo_p < OFF_QUARTER) begin
                    lfo_val = LFO_HALF + LFO_W'(lfo_p >> (PHASE_W - 17));
                end else if (lfo_p < OFF_QUARTER * PHASE_W'(3)) begin
                    lfo_val = LFO_ONE - LFO_W'((lfo_p - OFF_QUARTER) >> (PHASE_W - 17));
                end else begin
                    lfo_val = LFO_W'((lfo_p - OFF_QUARTER * PHASE_W'(3)) >> (PHASE_W - 17));
                end
            end
            LFO_SQUARE: lfo_val = (lfo_p < OFF_HALF) ? LFO_ONE : '0;
            LFO_SAW: begin
                if (lfo_p < OFF_HALF) begin
                    lfo_val = LFO_HALF + LFO_W'(lfo_p >> (PHASE_W - 16));
                end else begin
                    lfo_val = LFO_W'((lfo_p - OFF_HALF) >> (PHASE_W - 16));
                end
            end
            default: lfo_val = SINE_TAB[lfo_p[PHASE_W-1 -: SINE_BITS]];
        endcase
    end

    // delay = base + rounded sweep*lfo, clamped short of the line length
    always_comb begin
        dly = 23'(r_base_delay) + 23'((r_h + H_W'(32768)) >>> 16);
        if (dly > 23'(DELAY_LIMIT)) begin
            dly = 23'(DELAY_LIMIT);
        end
    end

    // output scaling
    assign wet   = r_ch ? r_acc_r : r_acc_l;
    assign rnd   = (r_fin + (FIN_W'(1) <<< 38)) >>> 39;
    assign y     = VAL_W'(r_ch ? r_dr : r_dl) + $signed(rnd[VAL_W-1:0]);
    always_comb begin
        if (y > VAL_W'(32767)) begin
            y_sat = 16'sh7FFF;
        end else if (y < -VAL_W'(32768)) begin
            y_sat = 16'sh8000;
        end else begin
            y_sat = y[SAMPLE_W-1:0];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_DMUL: begin
                m_a = $signed({17'b0, r_sweep_width});
                m_b = $signed({1'b0, r_lfo});
            end
            ST_IMUL: begin
                m_a = r_h[MUL_A_W-1:0];
                m_b = $signed({10'b0, frac});
            end
            ST_WMUL: begin
                m_a = MUL_A_W'(r_val);
                m_b = $signed({1'b0, (r_ch ? r_wr : r_wl)});
            end
            ST_FLO: begin
                m_a = $signed({13'b0, wet[WET_LO_W-1:0]});
                m_b = $signed({2'b0, r_mix_depth});
            end
            ST_FHI: begin
                m_a = MUL_A_W'($signed(wet[ACC_W-1:WET_LO_W]));
                m_b = $signed({2'b0, r_mix_depth});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    // voice count: zero acts as one, above five saturates
    always_comb begin
        if (r_voice_count == 3'd0) begin
            vc_in = 3'd1;
        end else if (r_voice_count > 3'd5) begin
            vc_in = 3'd5;
        end else begin
            vc_in = r_voice_count;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_clr == ADDR_W'(DELAY_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_LFO;
                end
            end
            ST_LFO:   n_state = (r_j + 3'd1 >= r_vc) ? ST_FLO : ST_DMUL;
            ST_DMUL:  n_state = ST_DEL;
            ST_DEL:   n_state = ST_POS;
            ST_POS:   n_state = ST_RD;
            ST_RD:    n_state = ST_RDW;
            ST_RDW:   n_state = (r_tap == tap_last) ? ST_IPREP : ST_RD;
            ST_IPREP: n_state = (is_cubic || is_linear) ? ST_IMUL : ST_IDONE;
            ST_IMUL:  n_state = imul_last ? ST_IDONE : ST_IMUL;
            ST_IDONE: n_state = ST_WMUL;
            ST_WMUL:  n_state = r_ch ? ST_LFO : ST_IPREP;
            ST_FLO:   n_state = ST_FHI;
            ST_FHI:   n_state = ST_FSAT;
            ST_FSAT:  n_state = r_ch ? ST_WRITE : ST_FLO;
            ST_WRITE: begin
                ram_we  = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign ram_waddr   = (r_state == ST_CLEAR) ? r_clr : r_wi;
    assign ram_wdata_l = (r_state == ST_CLEAR) ? '0 : r_dl;
    assign ram_wdata_r = (r_state == ST_CLEAR) ? '0 : r_dr;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay    <= BASE_W'(338688);
            r_sweep_width   <= BASE_W'(225792);
            r_mix_depth     <= MIX_W'(32768);
            r_phase_step    <= PHASE_W'(76);
            r_lfo_shape     <= LFO_SINE;
            r_interp_mode   <= INTERP_LINEAR;
            r_voice_count   <= VC_W'(2);
            r_stereo_spread <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_BASE_DELAY:    r_base_delay    <= i_cfg_data[BASE_W-1:0];
                CFG_SWEEP_WIDTH:   r_sweep_width   <= i_cfg_data[BASE_W-1:0];
                CFG_MIX_DEPTH:     r_mix_depth     <= i_cfg_data[MIX_W-1:0];
                CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data[PHASE_W-1:0];
                CFG_LFO_SHAPE:     r_lfo_shape     <= i_cfg_data[SHAPE_W-1:0];
                CFG_INTERP_MODE:   r_interp_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_VOICE_COUNT:   r_voice_count   <= i_cfg_data[VC_W-1:0];
                CFG_STEREO_SPREAD: r_stereo_spread <= i_cfg_data[0];
                default:           r_stereo_spread <= r_stereo_spread;
            endcase
        end
    end

    // control counters and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi        <= '0;
            r_phase     <= '0;
            r_clr       <= '0;
            r_j         <= '0;
            r_ch        <= 1'b0;
            r_tap       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output word once taken, reload it from the sequencer
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: r_clr <= r_clr + ADDR_W'(1);
                ST_IDLE: begin
                    r_j  <= '0;
                    r_ch <= 1'b0;
                end
                ST_POS:   r_tap <= '0;
                ST_RDW: begin
                    r_tap <= r_tap + 2'd1;
                    r_ch  <= 1'b0;
                end
                ST_IPREP: r_step <= '0;
                ST_IMUL:  r_step <= r_step + 2'd1;
                ST_WMUL: begin
                    r_ch <= !r_ch;
                    if (r_ch) begin
                        r_j <= r_j + 3'd1;
                    end
                end
                ST_FSAT:  r_ch <= !r_ch;
                ST_WRITE: begin
                    // advance the write index and the LFO phase once per frame
                    r_wi    <= r_wi + ADDR_W'(1);
                    r_phase <= r_phase + r_phase_step;
                end
                default: r_ch <= r_ch;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dl    <= $signed(s_axis_tdata[15:0]);
            r_dr    <= $signed(s_axis_tdata[31:16]);
            r_vc    <= vc_in;
            r_acc_l <= '0;
            r_acc_r <= '0;
        end
        // hold the output word until the slot frees, then load both channels
        if (out_load) begin
            r_out_data <= {r_yr, r_yl};
        end
        unique case (r_state)
            ST_LFO: begin
                r_lfo <= lfo_val;
                r_wl  <= w_left;
                r_wr  <= spread ? (W_ONE - w_left) : W_ONE;
            end
            ST_DMUL: r_h   <= m_p[H_W-1:0];
            ST_DEL:  r_pos <= dly[POS_W-1:0];
            // read position behind the write pointer, modulo the line span
            ST_POS:  r_pos <= {r_wi, {FRAC_W{1'b0}}} - r_pos;
            ST_RDW: begin
                r_xl[r_tap] <= $signed(ram_rdata_l);
                r_xr[r_tap] <= $signed(ram_rdata_r);
            end
            ST_IPREP: begin
                if (is_cubic) begin
                    r_h <= H_W'(a0);
                end else if (is_linear) begin
                    r_h <= H_W'(x1) - H_W'(x0);
                end else begin
                    r_h <= H_W'(x0) <<< 8;
                end
            end
            ST_IMUL:  r_h <= m_p[H_W-1:0] + addend;
            ST_IDONE: r_val <= is_cubic ? cubic_round[VAL_W-1:0] : r_h[VAL_W-1:0];
            ST_WMUL: begin
                if (r_ch) begin
                    r_acc_r <= r_acc_r + ACC_W'(m_p);
                end else begin
                    r_acc_l <= r_acc_l + ACC_W'(m_p);
                end
            end
            ST_FLO:  r_fin <= FIN_W'(m_p);
            ST_FHI:  r_fin <= r_fin + (FIN_W'(m_p) <<< WET_LO_W);
            ST_FSAT: begin
                if (!r_ch) begin
                    r_yl <= y_sat;
                end else begin
                    r_yr <= y_sat;
                end
            end
            default: r_val <= r_val;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    mvc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata_l),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_l)
    );

    mvc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata_r),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_r)
    );

    // one word at a time: input closes right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input accepted while a word is in work");

    // tap counter stays within the taps of the current mode
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDW) |-> (r_tap <= tap_last))
        else $error("tap counter beyond interpolation taps");

    // write index advances by exactly one per frame
    a_wi_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_wi == $past(r_wi) + ADDR_W'(1)))
        else $error("write index did not advance by one");

    // a new output word appears only from the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("output word raised outside the output step");

endmodule

// ===== sv/mvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
